>>> sv/uwt_pkg.sv
// Shared constants, types and position function for the Ulam word tester.
`timescale 1ns / 1ps
`default_nettype none

package uwt_pkg;

    localparam int MAX_LEN  = 16;
    localparam int WORD_W   = 16;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = 17;
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int POS_W    = MAX_LEN + 1;
    localparam int BIT_W    = 5;
    localparam int ROW_BITS = 1 << BIT_W;
    localparam int ROWS_W   = POS_W - BIT_W;

    // Row zero after reset: words 0 and 1 of length one, words 01 and 10 of length two.
    localparam logic [ROW_BITS-1:0] SEED_ROW = ROW_BITS'(32'h0000_001B);

    typedef struct packed {
        logic [POS_W-1:0] pre_pos;
        logic [POS_W-1:0] suf_pos;
        logic             skip;
    } split_probe_t;

    function automatic logic [POS_W-1:0] pos_of(input logic [LEN_W-1:0]  n,
                                                input logic [WORD_W-1:0] w);
        return ((POS_W'(1) << n) - POS_W'(2)) + POS_W'(w);
    endfunction

endpackage

`default_nettype wire

>>> sv/uwt_bitmap_ram.sv
// Bitmap memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module uwt_bitmap_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] ra_addr,
    output logic      [DATA_W-1:0] ra_data,
    input  wire logic [ADDR_W-1:0] rb_addr,
    output logic      [DATA_W-1:0] rb_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

`default_nettype wire

>>> sv/uwt_split_unit.sv
// Shared split unit: prefix and suffix bitmap positions for one split point.
`timescale 1ns / 1ps
`default_nettype none

module uwt_split_unit (
    input  wire logic [uwt_pkg::WORD_W-1:0] word,
    input  wire logic [uwt_pkg::LEN_W-1:0]  length,
    input  wire logic [uwt_pkg::LEN_W-1:0]  split,
    output uwt_pkg::split_probe_t           probe
);

    import uwt_pkg::*;

    logic [LEN_W-1:0]  rem;
    logic [WORD_W-1:0] pre;
    logic [WORD_W-1:0] suf;

    always_comb
    begin
        rem           = length - split;
        pre           = word >> rem;
        suf           = word & ~({WORD_W{1'b1}} << rem);
        probe.pre_pos = pos_of(split, pre);
        probe.suf_pos = pos_of(rem, suf);
        // drop the split into two equal halves holding the same word
        probe.skip    = (pre == suf) && ({split, 1'b0} == {1'b0, length});
    end

endmodule

`default_nettype wire

>>> sv/uwt_count_bank.sv
// Per-length counts of marked words.
`timescale 1ns / 1ps
`default_nettype none

module uwt_count_bank (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      inc,
    input  wire logic [uwt_pkg::IDX_W-1:0] idx,
    output logic      [uwt_pkg::CNT_W-1:0] count
);

    import uwt_pkg::*;

    logic [CNT_W-1:0] count_reg [0:MAX_LEN-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_LEN; k++)
            begin
                count_reg[k] <= (k < 2) ? CNT_W'(2) : '0;
            end
        end
        else if (inc)
        begin
            count_reg[idx] <= count_reg[idx] + CNT_W'(1);
        end
    end

    assign count = count_reg[idx];

endmodule

`default_nettype wire

>>> sv/ulam_word_tester.sv
// Ulam word tester top level: sequencer, bitmap memory and count bank.
//
// Request channel: req_valid/req_stall carry word and length (1..16).
// Response channel: rsp_valid/rsp_stall carry is_ulam_word and
// count_at_length, the marked total at that length after this word.
// One split point is checked per cycle through the shared split unit,
// with both bitmap reads on the two memory read ports; a final read of
// the word's own bit and a write back mark it when newly found.
// Lengths zero, one and above 16 skip the split search and go straight
// to the final state.
// The result sits in an output register, so a new word may be accepted
// while the previous result is still stalled; the block then waits in
// its final state until the output register frees up.
// After reset the block sweeps the 4096-row bitmap memory, one row per
// cycle, seeding lengths one and two; req_stall stays high until the
// sweep is done. Counts reset to two for lengths one and two, else zero.
// Lengths must be presented in increasing order for complete answers.
`timescale 1ns / 1ps
`default_nettype none

module ulam_word_tester (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [uwt_pkg::WORD_W-1:0] word,
    input  wire logic [uwt_pkg::LEN_W-1:0]  length,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic                            is_ulam_word,
    output logic      [uwt_pkg::CNT_W-1:0]  count_at_length
);

    import uwt_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_SPLIT  = 6'b000100,
        S_DRAIN  = 6'b001000,
        S_UPDATE = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t              state_reg,     state_next;
    logic [ROWS_W-1:0]   clr_reg,       clr_next;
    logic [WORD_W-1:0]   word_reg,      word_next;
    logic [LEN_W-1:0]    len_reg,       len_next;
    logic [LEN_W-1:0]    split_reg,     split_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                skip_reg,      skip_next;
    logic [BIT_W-1:0]    bit_a_reg,     bit_a_next;
    logic [BIT_W-1:0]    bit_b_reg,     bit_b_next;
    logic [BIT_W-1:0]    self_bit_reg,  self_bit_next;
    logic [1:0]          hits_reg,      hits_next;
    logic                ok_reg,        ok_next;
    logic                bad_len_reg,   bad_len_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg,    out_ok_next;
    logic [CNT_W-1:0]    out_cnt_reg,   out_cnt_next;

    split_probe_t        probe;
    logic [POS_W-1:0]    self_pos;
    logic                hit;
    logic                new_mark;
    logic                ram_we;
    logic [ROWS_W-1:0]   ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROWS_W-1:0]   ra_addr;
    logic [ROWS_W-1:0]   rb_addr;
    logic [ROW_BITS-1:0] ra_data;
    logic [ROW_BITS-1:0] rb_data;
    logic [IDX_W-1:0]    cnt_idx;
    logic [CNT_W-1:0]    cnt_value;
    logic                req_take;
    logic                rsp_take;
    logic                len_ok;
    logic [LEN_W-1:0]    len_minus_one;

    uwt_split_unit u_split (
        .word   (word_reg),
        .length (len_reg),
        .split  (split_reg),
        .probe  (probe)
    );

    uwt_bitmap_ram #(
        .ADDR_W (ROWS_W),
        .DATA_W (ROW_BITS)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .ra_addr (ra_addr),
        .ra_data (ra_data),
        .rb_addr (rb_addr),
        .rb_data (rb_data)
    );

    uwt_count_bank u_counts (
        .clk   (clk),
        .rst_n (rst_n),
        .inc   (new_mark),
        .idx   (cnt_idx),
        .count (cnt_value)
    );

    assign req_stall     = (state_reg != S_IDLE);
    assign req_take      = req_valid && !req_stall;
    assign rsp_take      = out_valid_reg && !rsp_stall;
    assign len_ok        = (length != '0) && (length <= LEN_W'(MAX_LEN));
    assign len_minus_one = len_reg - LEN_W'(1);
    assign cnt_idx       = len_minus_one[IDX_W-1:0];
    assign self_pos      = pos_of(len_reg, word_reg);
    assign hit           = chk_valid_reg && !skip_reg && ra_data[bit_a_reg]
                           && rb_data[bit_b_reg];
    assign new_mark      = (state_reg == S_UPDATE) && (hits_reg == 2'd1)
                           && !ra_data[self_bit_reg];

    always_comb
    begin
        ra_addr   = probe.pre_pos[POS_W-1:BIT_W];
        rb_addr   = probe.suf_pos[POS_W-1:BIT_W];
        ram_we    = 1'b0;
        ram_waddr = self_pos[POS_W-1:BIT_W];
        ram_wdata = ra_data | (ROW_BITS'(1) << self_bit_reg);
        if (state_reg == S_DRAIN)
        begin
            ra_addr = self_pos[POS_W-1:BIT_W];
        end
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = (clr_reg == '0) ? SEED_ROW : '0;
        end
        else if (new_mark)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        word_next      = word_reg;
        len_next       = len_reg;
        split_next     = split_reg;
        chk_valid_next = 1'b0;
        skip_next      = skip_reg;
        bit_a_next     = bit_a_reg;
        bit_b_next     = bit_b_reg;
        self_bit_next  = self_bit_reg;
        hits_next      = hits_reg;
        ok_next        = ok_reg;
        bad_len_next   = bad_len_reg;
        out_valid_next = rsp_take ? 1'b0 : out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_cnt_next   = out_cnt_reg;

        if (hit && (hits_reg != 2'd2))
        begin
            hits_next = hits_reg + 2'd1;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + ROWS_W'(1);
                if (clr_reg == {ROWS_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    word_next    = word & ~({WORD_W{1'b1}} << length);
                    len_next     = length;
                    split_next   = LEN_W'(1);
                    hits_next    = 2'd0;
                    bad_len_next = !len_ok;
                    ok_next      = len_ok;
                    if (len_ok && (length != LEN_W'(1)))
                    begin
                        state_next = S_SPLIT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SPLIT:
            begin
                chk_valid_next = 1'b1;
                skip_next      = probe.skip;
                bit_a_next     = probe.pre_pos[BIT_W-1:0];
                bit_b_next     = probe.suf_pos[BIT_W-1:0];
                split_next     = split_reg + LEN_W'(1);
                if (split_reg == len_minus_one)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                self_bit_next = self_pos[BIT_W-1:0];
                state_next    = S_UPDATE;
            end
            S_UPDATE:
            begin
                ok_next    = (hits_reg == 2'd1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_cnt_next   = bad_len_reg ? '0 : cnt_value;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        len_reg      <= len_next;
        split_reg    <= split_next;
        skip_reg     <= skip_next;
        bit_a_reg    <= bit_a_next;
        bit_b_reg    <= bit_b_next;
        self_bit_reg <= self_bit_next;
        hits_reg     <= hits_next;
        ok_reg       <= ok_next;
        bad_len_reg  <= bad_len_next;
        out_ok_reg   <= out_ok_next;
        out_cnt_reg  <= out_cnt_next;
    end

    assign rsp_valid       = out_valid_reg;
    assign is_ulam_word    = out_ok_reg;
    assign count_at_length = out_cnt_reg;

endmodule

`default_nettype wire

>>> sv/uwt_checker.sv
// Port-level checker for the Ulam word tester, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module uwt_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       req_valid,
    input wire logic                       req_stall,
    input wire logic                       rsp_valid,
    input wire logic                       rsp_stall,
    input wire logic                       is_ulam_word,
    input wire logic [uwt_pkg::CNT_W-1:0]  count_at_length
);

    import uwt_pkg::*;

    logic [1:0] pend_reg;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // track words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else if (req_take && !rsp_take)
        begin
            pend_reg <= pend_reg + 2'd1;
        end
        else if (rsp_take && !req_take)
        begin
            pend_reg <= pend_reg - 2'd1;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(is_ulam_word)
                                   && $stable(count_at_length))
        else $error("stalled response changed");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> req_stall)
        else $error("request taken twice in a row");

    a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without a pending word");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two words in flight");

    a_ulam_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && is_ulam_word |-> count_at_length != '0)
        else $error("Ulam word reported with zero count");

endmodule

bind ulam_word_tester uwt_checker u_uwt_checker (.*);

`default_nettype wire

>>> dv/ulam_word_tester_tb.sv
// Self-checking testbench for the Ulam word tester: driver, monitor and split-search predictor.
`timescale 1ns / 1ps

module ulam_word_tester_tb;

    import uwt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_WORDS   = 300;
    localparam int SETTLE_CYCLES = 30;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  len;
    } word_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] w;
        logic [LEN_W-1:0]  len;
        logic              ulam;
        logic [CNT_W-1:0]  total;
    } ulam_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [WORD_W-1:0]   word;
    logic [LEN_W-1:0]    length;
    logic                rsp_valid;
    logic                rsp_stall;
    logic                is_ulam_word;
    logic [CNT_W-1:0]    count_at_length;

    word_req_t           pending_words[$];
    ulam_result_t        expected_results[$];
    bit                  marked_words[int];
    int unsigned         ulam_list[1:MAX_LEN][$];
    logic [CNT_W-1:0]    marked_count[1:MAX_LEN];
    int                  sender_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  mismatches = 0;
    int                  cycle_count = 0;

    ulam_word_tester u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .word            (word),
        .length          (length),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .is_ulam_word    (is_ulam_word),
        .count_at_length (count_at_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int map_key(input int n, input int unsigned w);
        return (n << WORD_W) | int'(w);
    endfunction

    function automatic bit is_marked(input int n, input int unsigned w);
        return (marked_words.exists(map_key(n, w)) != 0);
    endfunction

    function automatic void mark_word(input int n, input int unsigned w);
        marked_words[map_key(n, w)] = 1'b1;
        ulam_list[n].push_back(w);
    endfunction

    function automatic void clear_ulam_state();
        marked_words.delete();
        for (int n = 1; n <= MAX_LEN; n++)
        begin
            ulam_list[n].delete();
            marked_count[n] = '0;
        end
        mark_word(1, 0);
        mark_word(1, 1);
        mark_word(2, 1);
        mark_word(2, 2);
        marked_count[1] = CNT_W'(2);
        marked_count[2] = CNT_W'(2);
    endfunction

    function automatic ulam_result_t score_word(input logic [WORD_W-1:0] w_in,
                                               input logic [LEN_W-1:0]  len_in);
        ulam_result_t res;
        int           len;
        int unsigned  wv;
        int unsigned  pre;
        int unsigned  suf;
        int           hits;
        res.w     = w_in;
        res.len   = len_in;
        res.ulam  = 1'b0;
        res.total = '0;
        len = int'(len_in);
        if (len == 0 || len > MAX_LEN)
            return res;
        wv = int'(w_in) & ((1 << len) - 1);
        if (len == 1)
            res.ulam = is_marked(1, wv);
        else
        begin
            hits = 0;
            for (int i = 1; i < len; i++)
            begin
                pre = wv >> (len - i);
                suf = wv & ((1 << (len - i)) - 1);
                if ((pre != suf || 2 * i != len) &&
                    is_marked(i, pre) && is_marked(len - i, suf))
                    hits++;
            end
            res.ulam = (hits == 1);
            if (res.ulam && !is_marked(len, wv))
            begin
                mark_word(len, wv);
                marked_count[len] = marked_count[len] + 1'b1;
            end
        end
        res.total = marked_count[len];
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] build_word(input int len);
        logic [31:0] junk;
        logic [31:0] base;
        int          cut;
        int unsigned pre;
        int unsigned suf;
        base = $urandom();
        if (len > 1 && $urandom_range(99) < 80)
        begin
            for (int tries = 0; tries < 4; tries++)
            begin
                cut = $urandom_range(len - 1, 1);
                if (ulam_list[cut].size() != 0 && ulam_list[len - cut].size() != 0)
                begin
                    pre  = ulam_list[cut][$urandom_range(ulam_list[cut].size() - 1)];
                    suf  = ulam_list[len - cut][$urandom_range(ulam_list[len - cut].size() - 1)];
                    base = (pre << (len - cut)) | suf;
                    break;
                end
            end
        end
        else if ($urandom_range(1) == 1 && ulam_list[len].size() != 0)
            base = ulam_list[len][$urandom_range(ulam_list[len].size() - 1)];
        if ($urandom_range(1) == 1)
        begin
            junk = $urandom();
            junk = junk << len;
            base = (base & ((32'd1 << len) - 1)) | junk;
        end
        return base[WORD_W-1:0];
    endfunction

    task automatic queue_word(input logic [WORD_W-1:0] w, input int len);
        word_req_t item;
        item.w   = w;
        item.len = LEN_W'(len);
        pending_words.push_back(item);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_sweeps(input int sweeps, inout int queued);
        int reps;
        int roll;
        for (int s = 0; s < sweeps; s++)
        begin
            for (int len = 1; len <= MAX_LEN; len++)
            begin
                reps = $urandom_range(2);
                for (int r = 0; r < reps; r++)
                begin
                    roll = $urandom_range(99);
                    if (roll < 2)
                        queue_word(WORD_W'($urandom()), 0);
                    else if (roll < 4)
                        queue_word(WORD_W'($urandom()),
                                   $urandom_range((1 << LEN_W) - 1, MAX_LEN + 1));
                    else if (roll < 7)
                        queue_word(WORD_W'($urandom()), $urandom_range(len, 1));
                    else if (roll < 12)
                        queue_word(WORD_W'($urandom()), len);
                    else
                        queue_word(build_word(len), len);
                    queued++;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic              v_next;
        logic [WORD_W-1:0] w_next;
        logic [LEN_W-1:0]  l_next;
        word_req_t         item;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            word      <= '0;
            length    <= '0;
        end
        else
        begin
            v_next = req_valid;
            w_next = word;
            l_next = length;
            if (req_valid && !req_stall)
            begin
                expected_results.push_back(score_word(word, length));
                v_next = 1'b0;
            end
            if (!v_next && pending_words.size() != 0 &&
                $urandom_range(99) >= sender_idle_pct)
            begin
                item   = pending_words.pop_front();
                v_next = 1'b1;
                w_next = item.w;
                l_next = item.len;
            end
            req_valid <= v_next;
            word      <= w_next;
            length    <= l_next;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        ulam_result_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected word result: ulam %b count %0d",
                                 is_ulam_word, count_at_length);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (is_ulam_word !== want.ulam || count_at_length !== want.total)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("mismatch word %h len %0d: exp %b %0d got %b %0d",
                                     want.w, want.len, want.ulam, want.total,
                                     is_ulam_word, count_at_length);
                    end
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        int queued;
        int pcts[4][2];
        rst_n = 1'b0;
        clear_ulam_state();
        pcts = '{'{0, 0}, '{88, 0}, '{0, 88}, '{17, 17}};

        queue_word(16'h0000, 0);
        queue_word(16'hFFFF, 31);
        queue_word(16'h0001, 17);
        queue_word(16'h0000, 1);
        queue_word(16'h0001, 1);
        queue_word(16'hFFFF, 1);
        for (int w = 0; w < 4; w++)
            queue_word(WORD_W'(w), 2);
        queue_word(16'hFFFE, 2);
        for (int w = 0; w < 8; w++)
            queue_word(WORD_W'(w), 3);
        queue_word(16'h0005, 4);
        queue_word(16'h000A, 4);
        queue_word(16'h0006, 4);
        queue_word(16'hFFFF, 16);
        queue_word(16'h0000, 16);
        queue_word(16'h0001, 2);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = pcts[ph][0];
            recv_stall_pct  = pcts[ph][1];
            queued = 0;
            while (queued < PHASE_WORDS)
            begin
                queue_sweeps(4, queued);
                wait_drained();
            end
        end

        recv_stall_pct  = 0;
        sender_idle_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> filelist.f
sv/uwt_pkg.sv
sv/uwt_bitmap_ram.sv
sv/uwt_split_unit.sv
sv/uwt_count_bank.sv
sv/ulam_word_tester.sv
sv/uwt_checker.sv
dv/ulam_word_tester_tb.sv
